FILE: rtl/egcd_pkg.sv
// Shared types and constants for the extended GCD block.
package egcd_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SIGN_BIT = 31;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture operands, form magnitudes
        logic div_start;  // set up a restoring division r0 / r1
        logic div_step;   // one quotient bit
        logic mul_step;   // one bit of q*a and q*b
        logic update;     // commit the Euclid step
        logic finish;     // apply sign fix, drive result beat
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic r1_zero;
        logic cnt_last;
    } t_status;

endpackage

FILE: rtl/egcd_datapath.sv
// Datapath: remainder/coefficient registers, shift-subtract divider and shift-add multiplier.
module egcd_datapath #(
    parameter int unsigned P_WIDTH = egcd_pkg::DATA_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  egcd_pkg::t_cmd         i_cmd,
    input  logic [P_WIDTH-1:0]     i_first_value,
    input  logic [P_WIDTH-1:0]     i_second_value,
    output egcd_pkg::t_status      o_status,
    output logic                   o_done,
    output logic [P_WIDTH-1:0]     o_divisor,
    output logic [P_WIDTH-1:0]     o_coef_first,
    output logic [P_WIDTH-1:0]     o_coef_second
);

    localparam int unsigned CW = $clog2(P_WIDTH) + 1;

    logic [P_WIDTH-1:0] r_r0, r_r1, r_u, r_v, r_a, r_b;
    logic [P_WIDTH-1:0] r_q, r_rem, r_qa, r_qb, r_mq;
    logic               r_neg_m, r_neg_n;
    logic [CW-1:0]      r_cnt;
    logic               r_done;
    logic [P_WIDTH-1:0] r_g, r_cu, r_cv;

    logic [P_WIDTH-1:0] mag_m, mag_n;
    logic [P_WIDTH:0]   rem_sh;
    logic [P_WIDTH:0]   rem_diff;

    assign mag_m = i_first_value[P_WIDTH-1]  ? (~i_first_value + 1'b1)  : i_first_value;
    assign mag_n = i_second_value[P_WIDTH-1] ? (~i_second_value + 1'b1) : i_second_value;

    // One restoring division step
    assign rem_sh   = {r_rem, r_q[P_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, r_r1};

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg_m <= i_first_value[P_WIDTH-1];
            r_neg_n <= i_second_value[P_WIDTH-1];
            r_u     <= P_WIDTH'(1);
            r_v     <= '0;
            r_a     <= '0;
            r_b     <= P_WIDTH'(1);
            if (mag_n == '0) begin
                r_r0 <= mag_m;
                r_r1 <= '0;
            end else if (mag_m == '0) begin
                // swap so the loop ends at once with u=0, v=1
                r_r0 <= mag_n;
                r_r1 <= '0;
                r_u  <= '0;
                r_v  <= P_WIDTH'(1);
            end else begin
                r_r0 <= mag_m;
                r_r1 <= mag_n;
            end
        end
        if (i_cmd.div_start) begin
            r_q   <= r_r0;
            r_rem <= '0;
            r_cnt <= CW'(P_WIDTH - 1);
        end
        if (i_cmd.div_step) begin
            if (!rem_diff[P_WIDTH]) begin
                r_rem <= rem_diff[P_WIDTH-1:0];
                r_q   <= {r_q[P_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[P_WIDTH-1:0];
                r_q   <= {r_q[P_WIDTH-2:0], 1'b0};
            end
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                // hand quotient to the multiplier
                r_cnt <= CW'(P_WIDTH - 1);
                r_qa  <= '0;
                r_qb  <= '0;
            end
        end
        if (i_cmd.div_step && r_cnt == '0) begin
            r_mq <= {r_q[P_WIDTH-2:0], ~rem_diff[P_WIDTH]};
        end
        if (i_cmd.mul_step) begin
            // MSB-first shift-add, modulo 2^W
            r_qa  <= {r_qa[P_WIDTH-2:0], 1'b0} + (r_mq[P_WIDTH-1] ? r_a : '0);
            r_qb  <= {r_qb[P_WIDTH-2:0], 1'b0} + (r_mq[P_WIDTH-1] ? r_b : '0);
            r_mq  <= {r_mq[P_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.update) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_u  <= r_a;
            r_a  <= r_u - r_qa;
            r_v  <= r_b;
            r_b  <= r_v - r_qb;
        end
        if (i_cmd.finish) begin
            r_g  <= r_r0;
            r_cu <= r_neg_m ? (~r_u + 1'b1) : r_u;
            r_cv <= r_neg_n ? (~r_v + 1'b1) : r_v;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_status.r1_zero  = (r_r1 == '0);
    assign o_status.cnt_last = (r_cnt == '0);
    assign o_done        = r_done;
    assign o_divisor     = r_g;
    assign o_coef_first  = r_cu;
    assign o_coef_second = r_cv;

endmodule

FILE: rtl/egcd_ctrl.sv
// Controller state machine sequencing the Euclid loop.
module egcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  egcd_pkg::t_status   i_status,
    output egcd_pkg::t_cmd      o_cmd,
    output logic                o_busy
);

    egcd_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            egcd_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = egcd_pkg::S_CHECK;
                end
            end
            egcd_pkg::S_LOAD: begin
                n_state = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_CHECK: begin
                if (i_status.r1_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = egcd_pkg::S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = egcd_pkg::S_DIV;
                end
            end
            egcd_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = egcd_pkg::S_MUL;
                end
            end
            egcd_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = egcd_pkg::S_UPD;
                end
            end
            egcd_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = egcd_pkg::S_CHECK;
            end
            egcd_pkg::S_DONE: begin
                n_state = egcd_pkg::S_IDLE;
            end
            default: begin
                n_state = egcd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/extended_gcd_32.sv
// Top level of the 32-bit extended GCD block.
// Pulse start while busy is low to launch one beat; o_valid then strobes for
// one cycle with gcd(|m|,|n|) and Bezout coefficients (u*m + v*n = g mod 2^32).
// Each Euclid iteration runs a check, 32 divider steps, 32 multiplier steps and
// an update; up to 46 iterations. A zero operand skips the loop and finishes
// from the first check. Results cannot be stalled.
module extended_gcd_32 #(
    parameter int unsigned P_WIDTH = egcd_pkg::DATA_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [P_WIDTH-1:0] i_first_value,
    input  logic [P_WIDTH-1:0] i_second_value,
    output logic               o_valid,
    output logic [P_WIDTH-1:0] o_divisor,
    output logic [P_WIDTH-1:0] o_coef_first,
    output logic [P_WIDTH-1:0] o_coef_second
);

    egcd_pkg::t_cmd    cmd;
    egcd_pkg::t_status status;
    logic              done;

    egcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    egcd_datapath #(.P_WIDTH(P_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_status       (status),
        .o_done         (done),
        .o_divisor      (o_divisor),
        .o_coef_first   (o_coef_first),
        .o_coef_second  (o_coef_second)
    );

    assign o_valid = done;

endmodule

FILE: rtl/egcd_checker.sv
// Port-level checker for the extended GCD block, bound to the top level.
module egcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_divisor
);

    // Launch makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after start");

    // Strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("valid longer than one cycle");

    // Result comes while still busy, then idle
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside busy window");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("not idle after result");

    // Result beat carries a known divisor
    a_divisor_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_divisor)) else $error("unknown divisor on result");

endmodule

bind extended_gcd_32 egcd_checker u_egcd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_divisor (o_divisor)
);
